>>> rtl/fll_pkg.sv
// Shared types, state and verdict codes, and character classes for the
// float literal lexer. No dependencies.
`default_nettype none

package fll_pkg;

    typedef logic [4:0] t_state;
    typedef logic [2:0] t_verdict;
    typedef logic [7:0] t_char;

    localparam t_state ST_DEFAULT   = 5'd0;
    localparam t_state ST_SLASH     = 5'd1;
    localparam t_state ST_MLCOMMENT = 5'd2;
    localparam t_state ST_SLCOMMENT = 5'd3;
    localparam t_state ST_ASTERISK  = 5'd4;
    localparam t_state ST_CHAR      = 5'd5;
    localparam t_state ST_STRING    = 5'd6;
    localparam t_state ST_BS_CHAR   = 5'd7;
    localparam t_state ST_BS_STRING = 5'd8;
    localparam t_state ST_BLOCK     = 5'd9;
    localparam t_state ST_NUMBER    = 5'd10;
    localparam t_state ST_DECIMAL   = 5'd11;
    localparam t_state ST_DOTSTART  = 5'd12;
    localparam t_state ST_BEGINE    = 5'd13;
    localparam t_state ST_SIGN      = 5'd14;
    localparam t_state ST_EXP       = 5'd15;
    localparam t_state ST_LONG      = 5'd16;
    localparam t_state ST_FLOAT     = 5'd17;

    localparam t_verdict V_NONE   = 3'd0;
    localparam t_verdict V_DOUBLE = 3'd1;
    localparam t_verdict V_FLOAT  = 3'd2;
    localparam t_verdict V_LONG   = 3'd3;
    localparam t_verdict V_ERROR  = 3'd4;

    localparam t_char CH_0      = 8'h30;
    localparam t_char CH_9      = 8'h39;
    localparam t_char CH_UC_A   = 8'h41;
    localparam t_char CH_UC_Z   = 8'h5A;
    localparam t_char CH_LC_A   = 8'h61;
    localparam t_char CH_LC_Z   = 8'h7A;
    localparam t_char CH_UNDER  = 8'h5F;
    localparam t_char CH_LC_E   = 8'h65;
    localparam t_char CH_UC_F   = 8'h46;
    localparam t_char CH_LC_F   = 8'h66;
    localparam t_char CH_UC_L   = 8'h4C;
    localparam t_char CH_LC_L   = 8'h6C;
    localparam t_char CH_STAR   = 8'h2A;
    localparam t_char CH_BSLASH = 8'h5C;
    localparam t_char CH_SLASH  = 8'h2F;
    localparam t_char CH_SQUOTE = 8'h27;
    localparam t_char CH_DQUOTE = 8'h22;
    localparam t_char CH_DOT    = 8'h2E;
    localparam t_char CH_PLUS   = 8'h2B;
    localparam t_char CH_MINUS  = 8'h2D;
    localparam t_char CH_LF     = 8'h0A;
    localparam t_char CH_CR     = 8'h0D;

    function automatic logic is_digit(input t_char c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input t_char c);
        return ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
               ((c >= CH_LC_A) && (c <= CH_LC_Z)) || (c == CH_UNDER);
    endfunction

    // State entered when a literal is closed by byte c.
    function automatic t_state after_literal(input t_char c);
        t_state s;
        if (is_letter(c))        s = ST_BLOCK;
        else if (c == CH_DQUOTE) s = ST_STRING;
        else if (c == CH_SQUOTE) s = ST_CHAR;
        else if (c == CH_SLASH)  s = ST_SLASH;
        else                     s = ST_DEFAULT;
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fll_if.sv
// Valid/ready channel interfaces for the float literal lexer.
// Depends on fll_pkg.
`default_nettype none

interface fll_in_if;
    logic            valid;
    logic            ready;
    fll_pkg::t_char  char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface fll_out_if;
    logic              valid;
    logic              ready;
    logic              byte_valid;
    fll_pkg::t_char    byte_out;
    fll_pkg::t_verdict verdict;

    modport source (output valid, output byte_valid, output byte_out, output verdict,
                    input ready);
    modport sink   (input valid, input byte_valid, input byte_out, input verdict,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/float_literal_lexer.sv
// Float literal lexer top level: input register, next-state logic, result register.
// Depends on fll_pkg and fll_if.
//
// Usage:
//   i_in carries one source byte per transfer (char_in). o_out carries the
//   results: an echoed literal byte (verdict none), a literal verdict
//   (double, float, long double; byte_valid low, byte_out zero) or an error
//   with the offending byte. Bytes that echo nothing and close no literal
//   produce no transfer on o_out.
//   A transferred byte is held in the input register; its result, if any, is
//   loaded into the result register and offered on o_out from there.
//   Throughput: one byte per cycle, set by the combinational next-state
//   logic, unless a result-producing byte waits behind a stalled result.
//   Reset (synchronous, i_rst_n low) returns the scanner to its default state
//   and empties both registers.
//   When o_out stalls, a waiting result holds; one more byte may sit in the
//   input register, and bytes that produce no result still drain through.
//   i_in.ready drops only when a result-producing byte is stuck behind a
//   stalled result. There is no end-of-input flush.
`default_nettype none

module float_literal_lexer (
    input  wire       i_clk,
    input  wire       i_rst_n,
    fll_in_if.sink    i_in,
    fll_out_if.source o_out
);

    logic               r_in_valid;
    fll_pkg::t_char     r_in_char;
    fll_pkg::t_state    r_state;
    logic               r_out_valid;
    logic               r_out_bv;
    fll_pkg::t_char     r_out_byte;
    fll_pkg::t_verdict  r_out_verdict;

    fll_pkg::t_state    n_state;
    logic               res_hit;
    logic               res_bv;
    fll_pkg::t_verdict  res_verdict;
    logic               out_free;
    logic               proc;
    logic               c_digit;
    logic               c_letter;
    fll_pkg::t_char     c;

    assign c        = r_in_char;
    assign c_digit  = fll_pkg::is_digit(c);
    assign c_letter = fll_pkg::is_letter(c);

    always_comb begin
        n_state     = r_state;
        res_hit     = 1'b0;
        res_bv      = 1'b0;
        res_verdict = fll_pkg::V_NONE;
        unique case (r_state)
            fll_pkg::ST_SLASH: begin
                if (c == fll_pkg::CH_SQUOTE)      n_state = fll_pkg::ST_CHAR;
                else if (c == fll_pkg::CH_DQUOTE) n_state = fll_pkg::ST_STRING;
                else if (c == fll_pkg::CH_SLASH)  n_state = fll_pkg::ST_SLCOMMENT;
                else if (c == fll_pkg::CH_STAR)   n_state = fll_pkg::ST_MLCOMMENT;
                else if (!c_digit && !c_letter)   n_state = fll_pkg::ST_BLOCK;
                else if (c_digit) begin
                    n_state = fll_pkg::ST_NUMBER;
                    res_hit = 1'b1;
                    res_bv  = 1'b1;
                end
            end
            fll_pkg::ST_MLCOMMENT: begin
                if (c == fll_pkg::CH_STAR) n_state = fll_pkg::ST_ASTERISK;
            end
            fll_pkg::ST_ASTERISK: begin
                if (c == fll_pkg::CH_SLASH)     n_state = fll_pkg::ST_DEFAULT;
                else if (c != fll_pkg::CH_STAR) n_state = fll_pkg::ST_MLCOMMENT;
            end
            fll_pkg::ST_SLCOMMENT: begin
                if (c == fll_pkg::CH_LF || c == fll_pkg::CH_CR) n_state = fll_pkg::ST_DEFAULT;
            end
            fll_pkg::ST_CHAR: begin
                if (c == fll_pkg::CH_BSLASH)      n_state = fll_pkg::ST_BS_CHAR;
                else if (c == fll_pkg::CH_SQUOTE) n_state = fll_pkg::ST_DEFAULT;
            end
            fll_pkg::ST_BS_CHAR: n_state = fll_pkg::ST_CHAR;
            fll_pkg::ST_STRING: begin
                if (c == fll_pkg::CH_BSLASH)      n_state = fll_pkg::ST_BS_STRING;
                else if (c == fll_pkg::CH_DQUOTE) n_state = fll_pkg::ST_DEFAULT;
            end
            fll_pkg::ST_BS_STRING: n_state = fll_pkg::ST_STRING;
            fll_pkg::ST_BLOCK: begin
                if (c == fll_pkg::CH_SLASH)     n_state = fll_pkg::ST_SLASH;
                else if (!c_digit && !c_letter) n_state = fll_pkg::ST_DEFAULT;
            end
            fll_pkg::ST_NUMBER: begin
                res_hit = 1'b1;
                res_bv  = 1'b1;
                if (c_digit) begin
                    n_state = fll_pkg::ST_NUMBER;
                end else if (c == fll_pkg::CH_LC_E) begin
                    n_state = fll_pkg::ST_BEGINE;
                end else if (c == fll_pkg::CH_DOT) begin
                    n_state = fll_pkg::ST_DECIMAL;
                end else begin
                    n_state     = fll_pkg::after_literal(c);
                    res_verdict = fll_pkg::V_ERROR;
                end
            end
            fll_pkg::ST_DOTSTART: begin
                res_hit = 1'b1;
                res_bv  = 1'b1;
                if (c_digit) begin
                    n_state = fll_pkg::ST_DECIMAL;
                end else begin
                    n_state     = fll_pkg::after_literal(c);
                    res_verdict = fll_pkg::V_ERROR;
                end
            end
            fll_pkg::ST_DECIMAL, fll_pkg::ST_EXP: begin
                res_hit = 1'b1;
                res_bv  = 1'b1;
                if (c_digit) begin
                    n_state = r_state;
                end else if (r_state == fll_pkg::ST_DECIMAL && c == fll_pkg::CH_LC_E) begin
                    n_state = fll_pkg::ST_BEGINE;
                end else if (c == fll_pkg::CH_UC_F || c == fll_pkg::CH_LC_F) begin
                    n_state = fll_pkg::ST_FLOAT;
                end else if (c == fll_pkg::CH_UC_L || c == fll_pkg::CH_LC_L) begin
                    n_state = fll_pkg::ST_LONG;
                end else if (c_letter ||
                             (r_state == fll_pkg::ST_DECIMAL && c == fll_pkg::CH_DOT)) begin
                    n_state     = fll_pkg::ST_BLOCK;
                    res_verdict = fll_pkg::V_ERROR;
                end else begin
                    n_state     = fll_pkg::after_literal(c);
                    res_bv      = 1'b0;
                    res_verdict = fll_pkg::V_DOUBLE;
                end
            end
            fll_pkg::ST_BEGINE, fll_pkg::ST_SIGN: begin
                res_hit = 1'b1;
                res_bv  = 1'b1;
                if (r_state == fll_pkg::ST_BEGINE &&
                    (c == fll_pkg::CH_PLUS || c == fll_pkg::CH_MINUS)) begin
                    n_state = fll_pkg::ST_SIGN;
                end else if (c_digit) begin
                    n_state = fll_pkg::ST_EXP;
                end else begin
                    n_state     = fll_pkg::after_literal(c);
                    res_verdict = fll_pkg::V_ERROR;
                end
            end
            fll_pkg::ST_LONG, fll_pkg::ST_FLOAT: begin
                res_hit = 1'b1;
                if (c_digit || c_letter) begin
                    n_state     = fll_pkg::ST_BLOCK;
                    res_bv      = 1'b1;
                    res_verdict = fll_pkg::V_ERROR;
                end else begin
                    n_state     = fll_pkg::after_literal(c);
                    res_verdict = (r_state == fll_pkg::ST_LONG) ? fll_pkg::V_LONG
                                                                : fll_pkg::V_FLOAT;
                end
            end
            // Default state, and unused codes which act like it
            default: begin
                if (c == fll_pkg::CH_SLASH)       n_state = fll_pkg::ST_SLASH;
                else if (c == fll_pkg::CH_SQUOTE) n_state = fll_pkg::ST_CHAR;
                else if (c == fll_pkg::CH_DQUOTE) n_state = fll_pkg::ST_STRING;
                else if (c_digit) begin
                    n_state = fll_pkg::ST_NUMBER;
                    res_hit = 1'b1;
                    res_bv  = 1'b1;
                end else if (c == fll_pkg::CH_DOT) begin
                    n_state = fll_pkg::ST_DOTSTART;
                    res_hit = 1'b1;
                    res_bv  = 1'b1;
                end else if (c_letter) n_state = fll_pkg::ST_BLOCK;
                else                   n_state = fll_pkg::ST_DEFAULT;
            end
        endcase
    end

    // A registered byte retires unless it has a result and the result slot is stalled
    assign out_free   = !r_out_valid || o_out.ready;
    assign proc       = r_in_valid && (!res_hit || out_free);
    assign i_in.ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= fll_pkg::ST_DEFAULT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (proc) begin
                r_state <= n_state;
            end
            if (proc && res_hit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_char <= i_in.char_in;
        end
        if (proc && res_hit) begin
            r_out_bv      <= res_bv;
            r_out_byte    <= res_bv ? c : 8'h00;
            r_out_verdict <= res_verdict;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.byte_valid = r_out_bv;
    assign o_out.byte_out   = r_out_byte;
    assign o_out.verdict    = r_out_verdict;

endmodule

`default_nettype wire

>>> rtl/fll_checker.sv
// Port-level checks for float_literal_lexer, attached by bind.
// Depends on fll_pkg.
`default_nettype none

module fll_checker (
    input wire                    i_clk,
    input wire                    i_rst_n,
    input wire                    i_out_valid,
    input wire                    i_out_ready,
    input wire                    i_byte_valid,
    input wire fll_pkg::t_char    i_byte_out,
    input wire fll_pkg::t_verdict i_verdict
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_byte_valid) && $stable(i_byte_out) && $stable(i_verdict))
        else $error("stalled result changed");

    // Echo and error carry a byte; literal verdicts carry none
    a_byte_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_byte_valid == (i_verdict == fll_pkg::V_NONE || i_verdict == fll_pkg::V_ERROR)))
        else $error("byte_valid does not match verdict");

    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_byte_out == 8'h00)
        else $error("byte_out not zero on a verdict");

endmodule

bind float_literal_lexer fll_checker u_fll_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_byte_valid (o_out.byte_valid),
    .i_byte_out   (o_out.byte_out),
    .i_verdict    (o_out.verdict)
);

`default_nettype wire
